[src/ltm_frame_parser_assert.svh]
// Assertion macros shared by the byte hunter and frame queue modules.
`ifndef LTM_FRAME_PARSER_ASSERT_SVH
`define LTM_FRAME_PARSER_ASSERT_SVH

// Flag any clock edge out of reset at which the expression is true.
`define LTM_ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("ltm_frame_parser: forbidden condition seen");

// Require the consequent in the cycle after the antecedent.
`define LTM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ltm_frame_parser: expected follow-up missing");

`endif

[src/ltm_pkg.sv]
// Shared types and constants of the LTM frame parser.
package ltm_pkg;

    localparam int PAYLOAD_MAX = 14;
    localparam int IDX_W       = 4;

    localparam logic [1:0] KIND_GPS    = 2'd0;
    localparam logic [1:0] KIND_ATT    = 2'd1;
    localparam logic [1:0] KIND_SENSOR = 2'd2;

    // One checked frame: its kind and the raw payload bytes.
    typedef struct packed {
        logic [1:0]                    kind;
        logic [PAYLOAD_MAX-1:0][7:0]   payload;
    } frame_t;

endpackage

[src/ltm_front.sv]
// Byte hunter: frame sync, payload capture and checksum check.
`include "ltm_frame_parser_assert.svh"
module ltm_front
    import ltm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    input  logic       q_full,
    output logic       q_push,
    output frame_t     q_data
);

    localparam logic [2:0] ST_HUNT   = 3'd0;
    localparam logic [2:0] ST_DOLLAR = 3'd1;
    localparam logic [2:0] ST_TEE    = 3'd2;
    localparam logic [2:0] ST_BODY   = 3'd3;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_T      = 8'h54;
    localparam logic [7:0] CH_G      = 8'h47;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_S      = 8'h53;

    function automatic logic [IDX_W-1:0] payload_len(input logic [1:0] kind);
        logic [IDX_W-1:0] len;
        case (kind)
            KIND_GPS: len = IDX_W'(14);
            KIND_ATT: len = IDX_W'(6);
            default:  len = IDX_W'(7);
        endcase
        return len;
    endfunction

    logic [2:0]       state_reg, state_next;
    logic [1:0]       kind_reg, kind_next;
    logic [IDX_W-1:0] index_reg, index_next;
    logic [7:0]       xor_reg, xor_next;
    logic [PAYLOAD_MAX-1:0][7:0] payload_reg;

    logic accept;
    logic at_check;
    logic store_en;

    // Take a word whenever the queue has room for a finished frame
    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    assign at_check = (state_reg == ST_BODY) && (index_reg >= payload_len(kind_reg));
    assign store_en = accept && (state_reg == ST_BODY) && !at_check
                      && (index_reg < IDX_W'(PAYLOAD_MAX));

    // Sync state machine
    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        index_next = index_reg;
        xor_next   = xor_reg;
        q_push     = 1'b0;
        if (accept)
        begin
            case (state_reg)
                ST_DOLLAR:
                begin
                    state_next = (rx_byte == CH_T) ? ST_TEE : ST_HUNT;
                end
                ST_TEE:
                begin
                    index_next = '0;
                    state_next = ST_BODY;
                    if (rx_byte == CH_G)
                        kind_next = KIND_GPS;
                    else if (rx_byte == CH_A)
                        kind_next = KIND_ATT;
                    else if (rx_byte == CH_S)
                        kind_next = KIND_SENSOR;
                    else
                        state_next = ST_HUNT;
                end
                ST_BODY:
                begin
                    xor_next = (index_reg == '0) ? rx_byte : (xor_reg ^ rx_byte);
                    if (at_check)
                    begin
                        q_push     = (xor_next == 8'd0);
                        state_next = ST_HUNT;
                    end
                    else
                    begin
                        index_next = index_reg + 1'b1;
                    end
                end
                default:
                begin
                    state_next = (rx_byte == CH_DOLLAR) ? ST_DOLLAR : ST_HUNT;
                end
            endcase
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_HUNT;
            kind_reg  <= KIND_GPS;
            index_reg <= '0;
            xor_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
            index_reg <= index_next;
            xor_reg   <= xor_next;
        end
    end

    // Capture payload bytes
    always_ff @(posedge clk)
    begin
        if (store_en)
            payload_reg[index_reg] <= rx_byte;
    end

    assign q_data.kind    = kind_reg;
    assign q_data.payload = payload_reg;

    `LTM_ASSERT_NEXT(a_push_back_to_hunt, clk, rst_n, q_push, state_reg == ST_HUNT)
    `LTM_ASSERT_NEVER(a_push_when_full, clk, rst_n, q_push && q_full)

endmodule

[src/ltm_fifo.sv]
// Short frame queue between the byte hunter and the decoder.
`include "ltm_frame_parser_assert.svh"
module ltm_fifo
    import ltm_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  frame_t push_data,
    output logic   full,
    input  logic   pop,
    output logic   not_empty,
    output frame_t pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    frame_t            mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    // Advance pointers with wrap
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Write entry
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    `LTM_ASSERT_NEVER(a_pop_when_empty, clk, rst_n, pop && !not_empty)
    `LTM_ASSERT_NEVER(a_count_overflow, clk, rst_n, count_reg > CNT_W'(DEPTH))

endmodule

[src/ltm_back.sv]
// Frame decoder with registered output word.
module ltm_back
    import ltm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  frame_t             q_data,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         frame_kind,
    output logic signed [31:0] value_a,
    output logic signed [31:0] value_b,
    output logic signed [31:0] value_c,
    output logic [7:0]         small_a,
    output logic [7:0]         small_b,
    output logic [9:0]         speed_kmh,
    output logic [5:0]         count_or_mode,
    output logic [1:0]         fix_type,
    output logic               armed,
    output logic               failsafe
);

    // (36*s + 5) * 6554 / 65536 equals (36*s + 5) / 10 for every byte s
    localparam logic [17:0] KMH_MUL = 18'd235944;
    localparam logic [25:0] KMH_ADD = 26'd32770;
    localparam logic [31:0] DEG_360 = 32'd360;

    logic out_valid_reg;
    logic load;

    logic [1:0]  kind_next;
    logic [31:0] a_next, b_next, c_next;
    logic [7:0]  sa_next, sb_next;
    logic [9:0]  kmh_next;
    logic [5:0]  cm_next;
    logic [1:0]  fx_next;
    logic        arm_next, fs_next;

    logic [1:0]  kind_reg;
    logic [31:0] a_reg, b_reg, c_reg;
    logic [7:0]  sa_reg, sb_reg;
    logic [9:0]  kmh_reg;
    logic [5:0]  cm_reg;
    logic [1:0]  fx_reg;
    logic        arm_reg, fs_reg;

    logic [PAYLOAD_MAX-1:0][7:0] p;
    logic [25:0] kmh_prod;
    logic [15:0] head16;
    logic [31:0] head_ext;

    assign p = q_data.payload;

    // Fill the output word when empty or being taken
    assign load  = q_valid && (!out_valid_reg || out_ready);
    assign q_pop = load;

    assign kmh_prod = ({18'd0, p[8]} * {8'd0, KMH_MUL}) + KMH_ADD;
    assign head16   = {p[5], p[4]};
    assign head_ext = {{16{head16[15]}}, head16};

    // Decode fields by kind
    always_comb
    begin
        kind_next = q_data.kind;
        a_next    = '0;
        b_next    = '0;
        c_next    = '0;
        sa_next   = '0;
        sb_next   = '0;
        kmh_next  = '0;
        cm_next   = '0;
        fx_next   = '0;
        arm_next  = 1'b0;
        fs_next   = 1'b0;
        case (q_data.kind)
            KIND_GPS:
            begin
                a_next   = {p[3], p[2], p[1], p[0]};
                b_next   = {p[7], p[6], p[5], p[4]};
                c_next   = {p[12], p[11], p[10], p[9]};
                sa_next  = p[8];
                kmh_next = kmh_prod[25:16];
                cm_next  = p[13][7:2];
                fx_next  = p[13][1:0];
            end
            KIND_ATT:
            begin
                a_next = {{16{p[1][7]}}, p[1], p[0]};
                b_next = {{16{p[3][7]}}, p[3], p[2]};
                c_next = head16[15] ? (head_ext + DEG_360) : head_ext;
            end
            default:
            begin
                a_next   = {16'd0, p[1], p[0]};
                b_next   = {16'd0, p[3], p[2]};
                sa_next  = p[4];
                sb_next  = p[5];
                arm_next = p[6][0];
                fs_next  = p[6][1];
                cm_next  = p[6][7:2];
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // Hold the result word until taken
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg <= kind_next;
            a_reg    <= a_next;
            b_reg    <= b_next;
            c_reg    <= c_next;
            sa_reg   <= sa_next;
            sb_reg   <= sb_next;
            kmh_reg  <= kmh_next;
            cm_reg   <= cm_next;
            fx_reg   <= fx_next;
            arm_reg  <= arm_next;
            fs_reg   <= fs_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign frame_kind    = kind_reg;
    assign value_a       = a_reg;
    assign value_b       = b_reg;
    assign value_c       = c_reg;
    assign small_a       = sa_reg;
    assign small_b       = sb_reg;
    assign speed_kmh     = kmh_reg;
    assign count_or_mode = cm_reg;
    assign fix_type      = fx_reg;
    assign armed         = arm_reg;
    assign failsafe      = fs_reg;

endmodule

[src/ltm_frame_parser.sv]
// Top level of the LTM telemetry frame parser.
// Input channel: one received serial word (rx_byte) per in_valid/in_ready
// handshake. The parser syncs on '$' 'T', reads a kind word (G, A or S),
// collects 14, 6 or 7 payload words and a checksum word.
// Output channel: one decoded word per good frame on out_valid/out_ready;
// frames with a bad checksum or unknown kind are dropped with no output.
// Throughput: one input word per cycle while the frame queue has room.
// Path: the frame enters the queue at the edge that accepts its checksum
// word and moves into the output register once it is at the head of the
// queue and the register is free; the decoded word is held there.
// The frame queue holds QUEUE_DEPTH finished frames; in_ready drops only
// when it is full, which needs the receiver to stall across whole frames.
// Reset: asynchronous, active low; the parser returns to hunting for '$',
// the queue empties and out_valid clears. Payload storage is not cleared.
// A stalled receiver holds the output word steady until out_ready.
module ltm_frame_parser
    import ltm_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         rx_byte,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         frame_kind,
    output logic signed [31:0] value_a,
    output logic signed [31:0] value_b,
    output logic signed [31:0] value_c,
    output logic [7:0]         small_a,
    output logic [7:0]         small_b,
    output logic [9:0]         speed_kmh,
    output logic [5:0]         count_or_mode,
    output logic [1:0]         fix_type,
    output logic               armed,
    output logic               failsafe
);

    logic   q_full, q_push, q_pop, q_valid;
    frame_t q_in, q_out;

    ltm_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .rx_byte  (rx_byte),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_in)
    );

    ltm_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_data  (q_out)
    );

    ltm_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_data        (q_out),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .frame_kind    (frame_kind),
        .value_a       (value_a),
        .value_b       (value_b),
        .value_c       (value_c),
        .small_a       (small_a),
        .small_b       (small_b),
        .speed_kmh     (speed_kmh),
        .count_or_mode (count_or_mode),
        .fix_type      (fix_type),
        .armed         (armed),
        .failsafe      (failsafe)
    );

endmodule
